/* hw/rtl/pli_pkg.sv */
// Shared types and codes for the positional list unit.
// Depends on nothing; used by pli_cell and positional_list_insert_delete_unit.
package pli_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 7;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CAPACITY_DEFAULT = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] entry_value;
        logic [STATUS_W-1:0]      status;
        logic [POS_W-1:0]         length;
        logic                     last;
    } t_out_beat;

    // Broadcast to every cell of the chain each cycle.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,   // cells above idx take left neighbor, cell idx takes value
        OP_DEL,   // cells from idx upward take right neighbor
        OP_ROT    // cells below idx take right neighbor, cell idx takes cell 0
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic [POS_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

/* hw/rtl/pli_cell.sv */
// One storage cell of the list chain: holds one entry, shifts with neighbors.
// Depends on pli_pkg.
module pli_cell import pli_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    input  logic signed [DATA_W-1:0] i_first,
    output logic signed [DATA_W-1:0] o_value
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            OP_INS: begin
                if (MY_IDX > i_ctl.idx) begin
                    n_value = i_left;
                end else if (MY_IDX == i_ctl.idx) begin
                    n_value = i_ctl.value;
                end
            end
            OP_DEL: begin
                if (MY_IDX >= i_ctl.idx) begin
                    n_value = i_right;
                end
            end
            OP_ROT: begin
                if (MY_IDX == i_ctl.idx) begin
                    n_value = i_first;
                end else if (MY_IDX < i_ctl.idx) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* hw/rtl/positional_list_insert_delete_unit.sv */
// Top level of the positional list unit: command decode, counter, output beat
// register and the row of pli_cell storage cells. Depends on pli_pkg, pli_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one command beat:
//   insert, delete or read out. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns result beats, the final one of a command marked last.
//   Insert and delete shift the affected cells at once in the accept cycle;
//   their single result beat appears in the output register on the next
//   cycle. Throughput is one command per cycle while the receiver keeps up.
//   Read out rotates the first length cells toward cell 0, one beat per cycle
//   while the receiver keeps up; an empty list gives one status beat. No new
//   command is taken until the last beat of a read is loaded. After length
//   rotations the list is back in its original order.
//   A receiver stall holds the output register; the chain and the command
//   input wait with it. Reset (synchronous, active low) empties the list and
//   drops any pending beat; cell contents are not cleared.
//   Unused command codes answer with a wrong-position status and change nothing.
module positional_list_insert_delete_unit import pli_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_remain, n_remain;
    logic            r_out_valid, n_out_valid;
    t_out_beat       r_out, n_out;

    t_cell_ctl                cell_ctl;
    logic signed [DATA_W-1:0] cell_q [CAPACITY];

    logic             out_free;
    logic             accept;
    logic [POS_W-1:0] cnt7;
    logic [POS_W-1:0] pos;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign cnt7       = POS_W'(r_count);
    assign pos        = i_in_data.position;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_remain    = r_remain;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        cell_ctl.op    = OP_HOLD;
        cell_ctl.idx   = '0;
        cell_ctl.value = i_in_data.value;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid       = 1'b1;
                    n_out.entry_value = '0;
                    n_out.status      = ST_OK;
                    n_out.length      = cnt7;
                    n_out.last        = 1'b1;
                    case (i_in_data.command)
                        CMD_INSERT: begin
                            if (r_count >= CAP_C) begin
                                n_out.status = ST_FULL;
                            end else if (r_count == '0 || pos == 7'd1) begin
                                cell_ctl.op  = OP_INS;
                                cell_ctl.idx = '0;
                            end else if (pos == '0) begin
                                cell_ctl.op  = OP_INS;
                                cell_ctl.idx = cnt7;
                            end else if (pos <= cnt7) begin
                                cell_ctl.op  = OP_INS;
                                cell_ctl.idx = pos - 7'd1;
                            end else begin
                                n_out.status = ST_BADPOS;
                            end
                            if (cell_ctl.op == OP_INS) begin
                                n_count      = r_count + 1'b1;
                                n_out.length = POS_W'(n_count);
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else if (pos == '0) begin
                                cell_ctl.op  = OP_DEL;
                                cell_ctl.idx = cnt7 - 7'd1;
                            end else if (pos <= cnt7) begin
                                cell_ctl.op  = OP_DEL;
                                cell_ctl.idx = pos - 7'd1;
                            end else begin
                                n_out.status = ST_BADPOS;
                            end
                            if (cell_ctl.op == OP_DEL) begin
                                n_count      = r_count - 1'b1;
                                n_out.length = POS_W'(n_count);
                            end
                        end
                        CMD_READ: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                // first entry goes out now, rest follow from S_READ
                                cell_ctl.op       = OP_ROT;
                                cell_ctl.idx      = cnt7 - 7'd1;
                                n_out.entry_value = cell_q[0];
                                n_out.last        = (r_count == CW'(1));
                                n_remain          = r_count - 1'b1;
                                if (r_count != CW'(1)) begin
                                    n_state = S_READ;
                                end
                            end
                        end
                        default: begin
                            n_out.status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    cell_ctl.op       = OP_ROT;
                    cell_ctl.idx      = cnt7 - 7'd1;
                    n_out_valid       = 1'b1;
                    n_out.entry_value = cell_q[0];
                    n_out.status      = ST_OK;
                    n_out.length      = cnt7;
                    n_out.last        = (r_remain == CW'(1));
                    n_remain          = r_remain - 1'b1;
                    if (r_remain == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    // Cell row: left neighbor feeds inserts, right neighbor feeds deletes and
    // rotation, cell 0 wraps around to the tail during read out.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_v;
        logic signed [DATA_W-1:0] right_v;
        if (g == 0) begin : g_lo
            assign left_v = cell_q[g];
        end else begin : g_lo
            assign left_v = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi
            assign right_v = cell_q[g];
        end else begin : g_hi
            assign right_v = cell_q[g+1];
        end
        pli_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_left  (left_v),
            .i_right (right_v),
            .i_first (cell_q[0]),
            .o_value (cell_q[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
